/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge
`define ASSERT_NOW(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/rkc_pkg.sv */
`timescale 1ns / 1ps

package rkc_pkg;

  localparam int unsigned QW = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TAPS,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_WAIT,
    ST_FEED
  } state_e;

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_e;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_PIXEL = 2'd1,
    REQ_DRAIN = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_RADIUS_X,
    REG_RADIUS_Y
  } reg_e;

  typedef struct packed {
    logic          vld;
    logic          byp;
    chan_e         ch;
    logic [QW-1:0] q;
  } dv_ctl_t;

endpackage

/* rtl/rkc_div_cell.sv */
`timescale 1ns / 1ps

module rkc_div_cell
  import rkc_pkg::*;
#(
  parameter int unsigned DW  = 32,
  parameter int unsigned BIT = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dv_ctl_t       ctl_i,
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] div_i,
  output dv_ctl_t       ctl_o,
  output logic [DW-1:0] rem_o,
  output logic [DW-1:0] div_o
);

  dv_ctl_t       ctl_d, ctl_q;
  logic [DW-1:0] rem_d, rem_q, div_q, trial;

  always_comb begin
    trial = div_i << BIT;
    ctl_d = ctl_i;
    rem_d = rem_i;
    if (ctl_i.vld && !ctl_i.byp && (rem_i >= trial)) begin
      rem_d        = rem_i - trial;
      ctl_d.q[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_i;
  end

  assign ctl_o = ctl_q;
  assign rem_o = rem_q;
  assign div_o = div_q;

endmodule

/* rtl/rgb_kernel_convolution.sv */
`timescale 1ns / 1ps

// Streaming RGB window filter. A coefficient load does not stall the input. A
// pixel or drain transaction that finds no output ready stalls the input only in
// the check state. One that produces an output holds the input through the
// check, tap, drain, wait and feed states, since the window taps are visited one
// per cycle through the single read port of the line memory and a three-stage
// multiply-accumulate. The three channels then pass through an eight-cell divider
// chain, overlapped with the next transactions; a further output waits until that
// chain and the output register are free. A register write restarts the frame.
module rgb_kernel_convolution
  import rkc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH      = 1024,
  parameter int unsigned MAX_RADIUS     = 3,
  parameter int unsigned COEF_FRAC_BITS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [5:0]         coef_index_i,
  input  logic signed [15:0] coef_value_i,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_red_o,
  output logic [7:0]         out_green_o,
  output logic [7:0]         out_blue_o,
  output logic [9:0]         out_col_o,
  output logic [15:0]        out_row_o,
  output logic               zero_area_o,
  output logic               frame_last_o
);

  localparam int unsigned KDIM  = 2 * MAX_RADIUS + 1;
  localparam int unsigned NCOEF = KDIM * KDIM;
  localparam int unsigned NROWS = 2 * MAX_RADIUS + 2;
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned CX    = CW + 1;
  localparam int unsigned XW    = CW + 2;
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SW    = $clog2(NROWS);
  localparam int unsigned TW    = SW + 2;
  localparam int unsigned RW    = $clog2(MAX_RADIUS + 1);
  localparam int unsigned KW    = $clog2(NCOEF);
  localparam int unsigned PW    = 25;
  localparam int unsigned AW    = PW + KW;
  localparam int unsigned CAW   = 16 + KW;
  localparam int unsigned DW    = CAW + 10;
  localparam int unsigned RDEP  = NROWS << CW;
  localparam int unsigned MW    = SW + CW;
  localparam int unsigned F     = COEF_FRAC_BITS;
  localparam logic signed [DW-1:0] SAT_INT = DW'(255) << F;
  localparam logic signed [DW-1:0] RND_INT = DW'(1) << (F - 1);

  // configuration
  logic [10:0] width_q;
  logic [15:0] height_q;
  logic [1:0]  rx_q, ry_q;
  logic        cfg_wr;

  logic [WW-1:0] eff_w;
  logic [15:0]   eff_h;
  logic [RW-1:0] eff_rx, eff_ry;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd640;
      height_q <= 16'd480;
      rx_q     <= 2'd1;
      ry_q     <= 2'd1;
    end else if (cfg_wr) begin
      case (reg_e'(paddr[3:2]))
        REG_WIDTH:    width_q  <= pwdata[10:0];
        REG_HEIGHT:   height_q <= pwdata[15:0];
        REG_RADIUS_X: rx_q     <= pwdata[1:0];
        REG_RADIUS_Y: ry_q     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[3:2]))
      REG_WIDTH:    prdata = 32'(width_q);
      REG_HEIGHT:   prdata = 32'(height_q);
      REG_RADIUS_X: prdata = 32'(rx_q);
      REG_RADIUS_Y: prdata = 32'(ry_q);
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    if (width_q == '0) begin
      eff_w = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_q);
    end
    eff_h  = (height_q == '0) ? 16'd1 : height_q;
    eff_rx = (32'(rx_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(rx_q);
    eff_ry = (32'(ry_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(ry_q);
  end

  // state machine
  state_e state_q, state_d;
  logic   in_acc, pix_acc, ld_acc, start, issue, feed, ready, last_tap;
  logic   out_valid_q, pend_q;
  chan_e  ch_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    pix_acc = 1'b0;
    ld_acc  = 1'b0;
    start   = 1'b0;
    issue   = 1'b0;
    feed    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (req_e'(req_type_i))
            REQ_LOAD:  ld_acc = 1'b1;
            REQ_PIXEL: begin
              pix_acc = 1'b1;
              state_d = ST_CHECK;
            end
            REQ_DRAIN: state_d = ST_CHECK;
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        if (ready) begin
          start   = 1'b1;
          state_d = ST_TAPS;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_TAPS: begin
        issue = 1'b1;
        if (last_tap) state_d = ST_DRAIN1;
      end
      ST_DRAIN1: state_d = ST_DRAIN2;
      ST_DRAIN2: state_d = ST_WAIT;
      ST_WAIT: begin
        if (!out_valid_q && !pend_q) state_d = ST_FEED;
      end
      ST_FEED: begin
        feed = 1'b1;
        if (ch_q == CH_BLUE) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // stream position
  logic [CW-1:0] in_col_q, in_col_d, out_col_q, out_col_d, pc;
  logic [15:0]   in_row_q, in_row_d, out_row_q, out_row_d, prow;
  logic [SW-1:0] in_slot_q, in_slot_d, out_slot_q, out_slot_d, ps;
  logic          tail_q, tail_d;
  logic [MW-1:0] wr_addr;
  logic [16:0]   ny, hm1;
  logic [CX-1:0] nx, wm1;
  logic          border, last_px;

  always_comb begin
    hm1 = {1'b0, eff_h} - 17'd1;
    wm1 = CX'(eff_w) - CX'(1);
    ny  = {1'b0, out_row_q} + 17'(eff_ry);
    nx  = CX'(out_col_q) + CX'(eff_rx);
    if (ny > hm1) ny = hm1;
    if (nx > wm1) nx = wm1;
    ready = tail_q || (ny < {1'b0, in_row_q}) ||
            ((ny == {1'b0, in_row_q}) && (nx < CX'(in_col_q)));
    border = (CX'(out_col_q) < CX'(eff_rx)) ||
             ((CX'(out_col_q) + CX'(eff_rx)) >= CX'(eff_w)) ||
             ({1'b0, out_row_q} < 17'(eff_ry)) ||
             (({1'b0, out_row_q} + 17'(eff_ry)) >= {1'b0, eff_h});
    last_px = ({1'b0, out_row_q} == hm1) && (CX'(out_col_q) == wm1);
  end

  always_comb begin
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    in_slot_d  = in_slot_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_slot_d = out_slot_q;
    tail_d     = tail_q;
    pc         = in_col_q;
    prow       = in_row_q;
    ps         = in_slot_q;
    if (cfg_wr) begin
      in_col_d   = '0;
      in_row_d   = '0;
      in_slot_d  = '0;
      out_col_d  = '0;
      out_row_d  = '0;
      out_slot_d = '0;
      tail_d     = 1'b0;
    end else if (pix_acc) begin
      if (tail_q) begin
        tail_d     = 1'b0;
        out_col_d  = '0;
        out_row_d  = '0;
        out_slot_d = '0;
      end
      if ((CX'(in_col_q) >= CX'(eff_w)) || (in_row_q >= eff_h)) begin
        pc         = '0;
        prow       = '0;
        ps         = '0;
        out_col_d  = '0;
        out_row_d  = '0;
        out_slot_d = '0;
        tail_d     = 1'b0;
      end
      if ((CX'(pc) + CX'(1)) >= CX'(eff_w)) begin
        in_col_d = '0;
        if (({1'b0, prow} + 17'd1) >= {1'b0, eff_h}) begin
          in_row_d  = '0;
          in_slot_d = '0;
          tail_d    = 1'b1;
        end else begin
          in_row_d  = prow + 16'd1;
          in_slot_d = (ps == SW'(NROWS - 1)) ? '0 : ps + SW'(1);
        end
      end else begin
        in_col_d  = pc + CW'(1);
        in_row_d  = prow;
        in_slot_d = ps;
      end
    end else if (start) begin
      if ((CX'(out_col_q) + CX'(1)) >= CX'(eff_w)) begin
        out_col_d = '0;
        if (({1'b0, out_row_q} + 17'd1) >= {1'b0, eff_h}) begin
          out_row_d  = '0;
          out_slot_d = '0;
          tail_d     = 1'b0;
        end else begin
          out_row_d  = out_row_q + 16'd1;
          out_slot_d = (out_slot_q == SW'(NROWS - 1)) ? '0 : out_slot_q + SW'(1);
        end
      end else begin
        out_col_d = out_col_q + CW'(1);
      end
    end
  end

  assign wr_addr = {ps, pc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
      tail_q     <= 1'b0;
    end else begin
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      in_slot_q  <= in_slot_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      out_slot_q <= out_slot_d;
      tail_q     <= tail_d;
    end
  end

  // current output pixel
  logic [CW-1:0] cur_x_q;
  logic [15:0]   cur_y_q;
  logic [SW-1:0] cur_slot_q;
  logic          border_q, last_q;

  always_ff @(posedge clk_i) begin
    if (start) begin
      cur_x_q    <= out_col_q;
      cur_y_q    <= out_row_q;
      cur_slot_q <= out_slot_q;
      border_q   <= border;
      last_q     <= last_px;
    end
  end

  // tap walk, column-major
  logic signed [RW:0]   dx_q, dy_q, rxs, rys;
  logic [KW-1:0]        k_q;
  logic signed [XW-1:0] sx;
  logic signed [17:0]   sy;
  logic signed [TW-1:0] ts;
  logic [SW-1:0]        rd_slot;
  logic [MW-1:0]        rd_addr;
  logic                 in_frame;

  assign rxs      = $signed({1'b0, eff_rx});
  assign rys      = $signed({1'b0, eff_ry});
  assign last_tap = (dx_q == rxs) && (dy_q == rys);

  always_comb begin
    sx = $signed({2'b00, cur_x_q}) + $signed({{(XW-RW-1){dx_q[RW]}}, dx_q});
    sy = $signed({2'b00, cur_y_q}) + $signed({{(17-RW){dy_q[RW]}}, dy_q});
    ts = $signed({2'b00, cur_slot_q}) + $signed({{(TW-RW-1){dy_q[RW]}}, dy_q});
    if (ts < 0) begin
      ts = ts + $signed(TW'(NROWS));
    end else if (ts >= $signed(TW'(NROWS))) begin
      ts = ts - $signed(TW'(NROWS));
    end
    rd_slot  = ts[SW-1:0];
    rd_addr  = {rd_slot, sx[CW-1:0]};
    in_frame = !sx[XW-1] && (sx[XW-2:0] < (XW-1)'(eff_w)) &&
               !sy[17] && (sy[16:0] < {1'b0, eff_h});
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      dx_q <= -rxs;
      dy_q <= -rys;
      k_q  <= '0;
    end else if (issue) begin
      k_q <= k_q + KW'(1);
      if (dy_q == rys) begin
        dy_q <= -rys;
        dx_q <= dx_q + (RW+1)'(1);
      end else begin
        dy_q <= dy_q + (RW+1)'(1);
      end
    end
  end

  // memories
  logic signed [15:0] coef_mem [0:NCOEF-1];
  logic [23:0]        row_mem  [0:RDEP-1];
  logic [NCOEF-1:0]   coef_vld_q;
  logic               coef_we;
  logic [KW-1:0]      coef_wa;

  assign coef_we = ld_acc && (32'(coef_index_i) < NCOEF);
  assign coef_wa = KW'(coef_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
    end else if (coef_we) begin
      coef_vld_q[coef_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (coef_we) coef_mem[coef_wa] <= coef_value_i;
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) row_mem[wr_addr] <= {red_i, green_i, blue_i};
  end

  // multiply-accumulate pipeline
  logic signed [15:0]   coef_rd_q, c, c_q;
  logic                 cvld_rd_q, a_vld_q, b_vld_q;
  logic [23:0]          pix_rd_q;
  logic signed [PW-1:0] pr_q, pg_q, pb_q;
  logic signed [AW-1:0] sr_q, sg_q, sb_q;
  logic signed [CAW-1:0] area_q;

  always_ff @(posedge clk_i) begin
    if (issue) begin
      coef_rd_q <= coef_mem[k_q];
      cvld_rd_q <= coef_vld_q[k_q];
      pix_rd_q  <= row_mem[rd_addr];
    end
  end

  assign c = cvld_rd_q ? coef_rd_q : 16'sd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      a_vld_q <= issue && in_frame;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pr_q <= $signed({1'b0, pix_rd_q[23:16]}) * c;
    pg_q <= $signed({1'b0, pix_rd_q[15:8]}) * c;
    pb_q <= $signed({1'b0, pix_rd_q[7:0]}) * c;
    c_q  <= c;
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      sr_q   <= '0;
      sg_q   <= '0;
      sb_q   <= '0;
      area_q <= '0;
    end else if (b_vld_q) begin
      sr_q   <= sr_q + AW'(pr_q);
      sg_q   <= sg_q + AW'(pg_q);
      sb_q   <= sb_q + AW'(pb_q);
      area_q <= area_q + CAW'(c_q);
    end
  end

  // clamp, round and divider set-up per channel
  logic signed [AW-1:0] ssel;
  logic signed [DW-1:0] se, sn, an, lim, rnd;
  logic [DW-1:0]        num, den;
  logic                 zero_cur, byp;
  logic [QW-1:0]        v;
  dv_ctl_t              feed_ctl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q <= CH_RED;
    end else if (feed) begin
      case (ch_q)
        CH_RED:   ch_q <= CH_GREEN;
        CH_GREEN: ch_q <= CH_BLUE;
        default:  ch_q <= CH_RED;
      endcase
    end
  end

  always_comb begin
    case (ch_q)
      CH_RED:   ssel = sr_q;
      CH_GREEN: ssel = sg_q;
      default:  ssel = sb_q;
    endcase
    zero_cur = border_q && (area_q == '0);
    se  = DW'(ssel);
    an  = area_q[CAW-1] ? -DW'(area_q) : DW'(area_q);
    sn  = area_q[CAW-1] ? -se : se;
    lim = (an <<< 8) - an;
    rnd = se + RND_INT;
    num = DW'(sn + sn + an);
    den = DW'(an + an);
    byp = 1'b1;
    v   = '0;
    if (!border_q) begin
      if (se <= 0) begin
        v = '0;
      end else if (se >= SAT_INT) begin
        v = 8'd255;
      end else begin
        v = rnd[F+7:F];
      end
    end else if (zero_cur) begin
      v = '0;
    end else if (sn <= 0) begin
      v = '0;
    end else if (sn >= lim) begin
      v = 8'd255;
    end else begin
      byp = 1'b0;
    end
    feed_ctl.vld = feed;
    feed_ctl.byp = byp;
    feed_ctl.ch  = ch_q;
    feed_ctl.q   = v;
  end

  // divider chain, one quotient bit per cell
  dv_ctl_t       ctl_c [0:QW];
  logic [DW-1:0] rem_c [0:QW];
  logic [DW-1:0] div_c [0:QW];

  assign ctl_c[0] = feed_ctl;
  assign rem_c[0] = num;
  assign div_c[0] = den;

  for (genvar j = 0; j < QW; j++) begin : g_cell
    rkc_div_cell #(
      .DW  (DW),
      .BIT (QW - 1 - j)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_c[j]),
      .rem_i  (rem_c[j]),
      .div_i  (div_c[j]),
      .ctl_o  (ctl_c[j+1]),
      .rem_o  (rem_c[j+1]),
      .div_o  (div_c[j+1])
    );
  end

  // transaction metadata for the pixel in the chain
  logic [CW-1:0] fx_q;
  logic [15:0]   fy_q;
  logic          fzero_q, flast_q;

  always_ff @(posedge clk_i) begin
    if (feed) begin
      fx_q    <= cur_x_q;
      fy_q    <= cur_y_q;
      fzero_q <= zero_cur;
      flast_q <= last_q;
    end
  end

  // output register
  logic          tail_blue;
  logic [7:0]    ored_q, ogreen_q, oblue_q;
  logic [CW-1:0] ocol_q;
  logic [15:0]   orow_q;
  logic          ozero_q, olast_q;

  assign tail_blue = ctl_c[QW].vld && (ctl_c[QW].ch == CH_BLUE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      if (tail_blue) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (feed && (ch_q == CH_BLUE)) begin
        pend_q <= 1'b1;
      end else if (tail_blue) begin
        pend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_c[QW].vld) begin
      case (ctl_c[QW].ch)
        CH_RED:   ored_q   <= ctl_c[QW].q;
        CH_GREEN: ogreen_q <= ctl_c[QW].q;
        default: begin
          oblue_q <= ctl_c[QW].q;
          ocol_q  <= fx_q;
          orow_q  <= fy_q;
          ozero_q <= fzero_q;
          olast_q <= flast_q;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_red_o    = ored_q;
  assign out_green_o  = ogreen_q;
  assign out_blue_o   = oblue_q;
  assign out_col_o    = 10'(ocol_q);
  assign out_row_o    = orow_q;
  assign zero_area_o  = ozero_q;
  assign frame_last_o = olast_q;

endmodule

/* rtl/rkc_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rkc_checker
  import rkc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_i,
  input logic [1:0] req_type_i,
  input logic       out_valid_i,
  input logic       out_stall_i,
  input logic [7:0] out_red_i,
  input logic [7:0] out_green_i,
  input logic [7:0] out_blue_i,
  input logic [9:0] out_col_i,
  input logic [15:0] out_row_i,
  input logic       zero_area_i
);

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, out_valid_i && out_stall_i, out_valid_i && $stable(out_red_i) && $stable(out_col_i) && $stable(out_row_i))
  // a taken result is never followed by another in the next cycle
  `ASSERT_NEXT(a_out_gap, out_valid_i && !out_stall_i, !out_valid_i)
  // zero coefficient area gives black
  `ASSERT_NOW(a_zero_black, !(out_valid_i && zero_area_i) || (out_red_i == 8'd0 && out_green_i == 8'd0 && out_blue_i == 8'd0))
  // the input is not stalled in the cycle after a coefficient load
  `ASSERT_NEXT(a_load_quick, in_valid_i && !in_stall_i && req_type_i == REQ_LOAD, !in_stall_i)

endmodule

bind rgb_kernel_convolution rkc_checker u_rkc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .req_type_i  (req_type_i),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_red_i   (out_red_o),
  .out_green_i (out_green_o),
  .out_blue_i  (out_blue_o),
  .out_col_i   (out_col_o),
  .out_row_i   (out_row_o),
  .zero_area_i (zero_area_o)
);
